>>> rtl/rls_pkg.sv
// Shared types, codes and helper functions of the RGB LED strip serializer.
`timescale 1ns / 1ps
package rls_pkg;

  // Default pixel memory depth
  localparam int MAX_PIXELS_DEF = 256;

  // One stored pixel: red [23:16], green [15:8], blue [7:0]
  localparam int PIXEL_W = 24;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_CNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 3'd6;

  // Configuration reset values
  localparam logic [7:0]  RST_BRIGHTNESS = 8'd255;
  localparam logic [8:0]  RST_PIXEL_CNT  = 9'd1;
  localparam logic [7:0]  RST_ZERO_HIGH  = 8'd3;
  localparam logic [7:0]  RST_ZERO_LOW   = 8'd9;
  localparam logic [7:0]  RST_ONE_HIGH   = 8'd9;
  localparam logic [7:0]  RST_ONE_LOW    = 8'd3;
  localparam logic [14:0] RST_GAP        = 15'd500;

  // Byte order on the line
  localparam logic [1:0] BYTE_GREEN = 2'd0;
  localparam logic [1:0] BYTE_RED   = 2'd1;
  localparam logic [1:0] BYTE_BLUE  = 2'd2;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_START = 2'd2,
    ACT_TICK  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BUSY  = 2'd2
  } status_e;

  typedef struct packed {
    action_e    action;
    logic [7:0] pixel_index;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } in_word_t;

  typedef struct packed {
    logic       line_level;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       busy_res;
    logic       frame_done;
    status_e    status;
  } out_word_t;

  // floor(c * b / 255): exact for products below 65535
  function automatic logic [7:0] scale_color(logic [7:0] c, logic [7:0] b);
    logic [15:0] prod;
    logic [16:0] sum;
    prod = c * b;
    sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
    return sum[15:8];
  endfunction

  // Pick one byte of a pixel in line order
  function automatic logic [7:0] pick_byte(logic [PIXEL_W-1:0] px, logic [1:0] k);
    logic [7:0] b;
    case (k)
      BYTE_GREEN: b = px[15:8];
      BYTE_RED:   b = px[23:16];
      default:    b = px[7:0];
    endcase
    return b;
  endfunction

  // Treat a zero duration as one tick
  function automatic logic [7:0] at_least_one(logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

endpackage

>>> rtl/rls_if.sv
// Valid/ready channel interfaces for input and result words.
`timescale 1ns / 1ps
interface rls_in_if;
  logic              valid;
  logic              ready;
  rls_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rls_out_if;
  logic               valid;
  logic               ready;
  rls_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/rls_ram.sv
// Generic one-write, two-read RAM with registered read data.
`timescale 1ns / 1ps
module rls_ram #(
  parameter int WIDTH = rls_pkg::PIXEL_W,
  parameter int DEPTH = rls_pkg::MAX_PIXELS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_a_en_i,
  input  logic [AW-1:0]    rd_a_addr_i,
  output logic [WIDTH-1:0] rd_a_data_o,
  input  logic             rd_b_en_i,
  input  logic [AW-1:0]    rd_b_addr_i,
  output logic [WIDTH-1:0] rd_b_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_a_q;
  logic [WIDTH-1:0] rd_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Read ports, hold when not enabled
  always_ff @(posedge clk_i) begin
    if (rd_a_en_i) begin
      rd_a_q <= mem_q[rd_a_addr_i];
    end
    if (rd_b_en_i) begin
      rd_b_q <= mem_q[rd_b_addr_i];
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

>>> rtl/rgb_led_strip_serializer.sv
// Top level: pixel memory, brightness scaling and one-wire waveform sequencer.
//
//   channel  dir  modport  payload                        accepted when
//   in_i     in   sink     action, index, red/green/blue  valid & ready
//   out_o    out  source   level, colour, busy, done, st  valid & ready
//   cfg      in   -        cfg_idx_i, cfg_data_i          cfg_we_i
//
// One word per clock sustained while out_o is ready; a taken word passes the input
// register, then the result register after the memory read and scale.
// Reset clears control state and the per-pixel valid bits at once, so there is
// no clearing pass. A stalled result register stalls the input stage, and the
// input stays ready while the result register drains.
`timescale 1ns / 1ps
module rgb_led_strip_serializer #(
  parameter int MAX_PIXELS = rls_pkg::MAX_PIXELS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rls_in_if.sink                         in_i,
  rls_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [rls_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rls_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int PW = rls_pkg::PIXEL_W;

  localparam logic [1:0] PH_HIGH = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_GAP  = 2'd2;

  // Configuration registers
  logic [7:0]  brightness_q, zero_high_q, zero_low_q, one_high_q, one_low_q;
  logic [8:0]  pixel_cnt_q;
  logic [14:0] gap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= rls_pkg::RST_BRIGHTNESS;
      pixel_cnt_q  <= rls_pkg::RST_PIXEL_CNT;
      zero_high_q  <= rls_pkg::RST_ZERO_HIGH;
      zero_low_q   <= rls_pkg::RST_ZERO_LOW;
      one_high_q   <= rls_pkg::RST_ONE_HIGH;
      one_low_q    <= rls_pkg::RST_ONE_LOW;
      gap_q        <= rls_pkg::RST_GAP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rls_pkg::CFG_BRIGHTNESS: brightness_q <= cfg_data_i[7:0];
        rls_pkg::CFG_PIXEL_CNT:  pixel_cnt_q  <= cfg_data_i[8:0];
        rls_pkg::CFG_ZERO_HIGH:  zero_high_q  <= cfg_data_i[7:0];
        rls_pkg::CFG_ZERO_LOW:   zero_low_q   <= cfg_data_i[7:0];
        rls_pkg::CFG_ONE_HIGH:   one_high_q   <= cfg_data_i[7:0];
        rls_pkg::CFG_ONE_LOW:    one_low_q    <= cfg_data_i[7:0];
        rls_pkg::CFG_GAP:        gap_q        <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Clamp pixel count to the memory depth
  logic [8:0] live_cnt;
  assign live_cnt = (32'(pixel_cnt_q) > MAX_PIXELS) ? 9'(MAX_PIXELS) : pixel_cnt_q;

  // Handshake control
  logic              in_vld_q, out_vld_q;
  rls_pkg::in_word_t in_q;
  rls_pkg::out_word_t out_q, out_d;
  logic              adv, acc;

  assign adv         = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !in_vld_q || adv;
  assign acc         = in_i.valid && in_i.ready;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // Sequencer state
  logic        sending_q, sending_d;
  logic [8:0]  pix_q, pix_d;
  logic [1:0]  byte_q, byte_d;
  logic [2:0]  bit_q, bit_d;
  logic [1:0]  phase_q, phase_d;
  logic [14:0] tick_q, tick_d;
  logic [7:0]  shift_q, shift_d;

  // Memory write side
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [PW-1:0] wr_data;

  // Read port A follows the word being accepted; port B prefetches the next byte
  logic [AW-1:0] rd_a_addr, rd_b_addr;
  logic [PW-1:0] ram_a, ram_b;
  logic [8:0]    nxt_pix;
  logic [1:0]    nxt_byte;
  logic          fetch_next;

  assign rd_a_addr  = AW'(in_i.data.pixel_index);
  assign nxt_byte   = (byte_q >= rls_pkg::BYTE_BLUE) ? rls_pkg::BYTE_GREEN : byte_q + 2'd1;
  assign nxt_pix    = (byte_q >= rls_pkg::BYTE_BLUE) ? pix_q + 9'd1 : pix_q;
  assign fetch_next = sending_q && (phase_q == PH_HIGH || phase_q == PH_LOW);
  // Outside pixel data, keep pixel zero ready for the next frame start
  assign rd_b_addr  = fetch_next ? AW'(nxt_pix) : '0;

  rls_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_PIXELS)
  ) u_ram (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_a_en_i   (acc),
    .rd_a_addr_i (rd_a_addr),
    .rd_a_data_o (ram_a),
    .rd_b_en_i   (1'b1),
    .rd_b_addr_i (rd_b_addr),
    .rd_b_data_o (ram_b)
  );

  // Valid bits stand for the zeroed memory after reset; bypass same-edge writes
  logic [MAX_PIXELS-1:0] valid_q;
  logic                  a_vld_q, a_hit_q, b_vld_q, b_hit_q;
  logic [PW-1:0]         a_byp_q, b_byp_q;
  logic [PW-1:0]         px_a, px_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      a_vld_q <= 1'b0;
      a_hit_q <= 1'b0;
      b_vld_q <= 1'b0;
      b_hit_q <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (acc) begin
        a_vld_q <= valid_q[rd_a_addr];
        a_hit_q <= wr_en && (wr_addr == rd_a_addr);
      end
      b_vld_q <= valid_q[rd_b_addr];
      b_hit_q <= wr_en && (wr_addr == rd_b_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_byp_q <= wr_data;
    end
    b_byp_q <= wr_data;
  end

  assign px_a = a_hit_q ? a_byp_q : (a_vld_q ? ram_a : '0);
  assign px_b = b_hit_q ? b_byp_q : (b_vld_q ? ram_b : '0);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      in_q <= in_i.data;
    end
  end

  // Execute one word: memory access, refresh control and one line tick
  always_comb begin
    logic        in_range;
    logic [14:0] tick_inc;
    logic [14:0] dur;
    logic [8:0]  new_pix;
    logic [1:0]  new_byte;

    in_range = {1'b0, in_q.pixel_index} < live_cnt;
    tick_inc = tick_q + 15'd1;
    dur      = '0;
    new_pix  = pix_q;
    new_byte = byte_q;

    sending_d = sending_q;
    pix_d     = pix_q;
    byte_d    = byte_q;
    bit_d     = bit_q;
    phase_d   = phase_q;
    tick_d    = tick_q;
    shift_d   = shift_q;

    wr_en   = 1'b0;
    wr_addr = AW'(in_q.pixel_index);
    wr_data = {rls_pkg::scale_color(in_q.red_in, brightness_q),
               rls_pkg::scale_color(in_q.green_in, brightness_q),
               rls_pkg::scale_color(in_q.blue_in, brightness_q)};

    out_d            = '0;
    out_d.status     = rls_pkg::ST_OK;

    unique case (in_q.action)
      rls_pkg::ACT_WRITE: begin
        if (sending_q) begin
          out_d.status = rls_pkg::ST_BUSY;
        end else if (!in_range) begin
          out_d.status = rls_pkg::ST_RANGE;
        end else begin
          wr_en = adv;
        end
      end
      rls_pkg::ACT_READ: begin
        if (!in_range) begin
          out_d.status = rls_pkg::ST_RANGE;
        end else begin
          out_d.red_out   = px_a[23:16];
          out_d.green_out = px_a[15:8];
          out_d.blue_out  = px_a[7:0];
        end
      end
      rls_pkg::ACT_START: begin
        if (sending_q) begin
          out_d.status = rls_pkg::ST_BUSY;
        end else begin
          sending_d = 1'b1;
          pix_d     = '0;
          byte_d    = rls_pkg::BYTE_GREEN;
          bit_d     = '0;
          tick_d    = '0;
          if (live_cnt == 9'd0) begin
            phase_d = PH_GAP;
            shift_d = '0;
          end else begin
            phase_d = PH_HIGH;
            shift_d = rls_pkg::pick_byte(px_b, rls_pkg::BYTE_GREEN);
          end
        end
      end
      rls_pkg::ACT_TICK: begin
        if (sending_q) begin
          case (phase_q)
            PH_HIGH: begin
              out_d.line_level = 1'b1;
              dur = {7'd0, rls_pkg::at_least_one(shift_q[7] ? one_high_q : zero_high_q)};
              if (tick_inc >= dur) begin
                tick_d  = '0;
                phase_d = PH_LOW;
              end else begin
                tick_d = tick_inc;
              end
            end
            PH_LOW: begin
              dur = {7'd0, rls_pkg::at_least_one(shift_q[7] ? one_low_q : zero_low_q)};
              if (tick_inc >= dur) begin
                tick_d  = '0;
                shift_d = {shift_q[6:0], 1'b0};
                if (bit_q == 3'd7) begin
                  // End of byte: step to the next byte or into the gap
                  bit_d    = '0;
                  new_pix  = nxt_pix;
                  new_byte = nxt_byte;
                  pix_d    = new_pix;
                  byte_d   = new_byte;
                  if (new_pix >= live_cnt) begin
                    phase_d = PH_GAP;
                  end else begin
                    shift_d = rls_pkg::pick_byte(px_b, new_byte);
                    phase_d = PH_HIGH;
                  end
                end else begin
                  bit_d   = bit_q + 3'd1;
                  phase_d = PH_HIGH;
                end
              end else begin
                tick_d = tick_inc;
              end
            end
            default: begin
              // Latch gap; drop back to idle at its end
              dur = (gap_q == 15'd0) ? 15'd1 : gap_q;
              if (tick_inc >= dur) begin
                out_d.frame_done = 1'b1;
                sending_d = 1'b0;
                pix_d     = '0;
                byte_d    = rls_pkg::BYTE_GREEN;
                bit_d     = '0;
                phase_d   = PH_HIGH;
                tick_d    = '0;
                shift_d   = '0;
              end else begin
                tick_d = tick_inc;
              end
            end
          endcase
        end
      end
      default: ;
    endcase

    out_d.busy_res = sending_d;
  end

  // Advance sequencer state with each executed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sending_q <= 1'b0;
      pix_q     <= '0;
      byte_q    <= rls_pkg::BYTE_GREEN;
      bit_q     <= '0;
      phase_q   <= PH_HIGH;
      tick_q    <= '0;
      shift_q   <= '0;
    end else if (adv) begin
      sending_q <= sending_d;
      pix_q     <= pix_d;
      byte_q    <= byte_d;
      bit_q     <= bit_d;
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      shift_q   <= shift_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

endmodule
